// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the byte FIFO core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, idle during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, idle during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/brbf_pkg.sv -----
// Types and constants of the byte FIFO core
package brbf_pkg;

  localparam int REQ_W    = 2;
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 11;
  localparam int CAP_W    = 11;
  localparam int USED_W   = 10;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [CAP_W-1:0] CAP_MIN   = 11'd2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

  // One queued command
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // Command handed from front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ----- rtl/core/brbf_front.sv -----
// Front end: takes commands, drops unused codes, queues them for the back end
module brbf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [brbf_pkg::REQ_W-1:0]   req_type,
  input  logic [brbf_pkg::DATA_W-1:0]  data_byte,
  input  logic [brbf_pkg::LEN_W-1:0]   burst_length,
  output brbf_pkg::cmd_chan_t          q_out,
  input  logic                         q_pop
);

  brbf_pkg::cmd_t q_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  // Accept while a slot is free; unused request code gives no transfer to the back
  assign busy = (count == 2'd2);
  assign push = start && !busy && (req_type != brbf_pkg::REQ_NONE);
  assign pop  = q_pop && (count != 2'd0);

  assign q_out.valid = (count != 2'd0);
  assign q_out.cmd   = q_mem[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{req: req_type, data: data_byte, len: burst_length};
    end
  end

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/brbf_back.sv -----
// Back end: carries out writes, reads and clears on the circular store
module brbf_back #(
  parameter int STORE_DEPTH = 1024,
  parameter int MAX_READ    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [brbf_pkg::CAP_W-1:0]     cfg_data,
  input  brbf_pkg::cmd_chan_t            q_in,
  output logic                           q_pop,
  output logic                           idle,
  output logic                           done,
  output logic [brbf_pkg::STATUS_W-1:0]  status,
  output logic [brbf_pkg::DATA_W-1:0]    read_byte,
  output logic                           last,
  output logic [brbf_pkg::USED_W-1:0]    used_count,
  output logic [brbf_pkg::CAP_W-1:0]     free_count
);

  localparam int PW    = $clog2(STORE_DEPTH);
  localparam int RC_W  = $clog2(MAX_READ + 1);
  localparam int CAP_W = brbf_pkg::CAP_W;

  function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    if (c < brbf_pkg::CAP_MIN) begin
      r = brbf_pkg::CAP_MIN;
    end else if (32'(c) > STORE_DEPTH) begin
      r = CAP_W'(STORE_DEPTH);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Byte store and its registered read port
  logic [brbf_pkg::DATA_W-1:0] mem [STORE_DEPTH];
  logic [brbf_pkg::DATA_W-1:0] mem_q;

  // State
  logic [PW-1:0]                 wp, wp_next;
  logic [PW-1:0]                 rp, rp_next;
  logic [CAP_W-1:0]              used, used_next;
  logic [CAP_W-1:0]              cap_eff;
  logic [brbf_pkg::LEN_W-1:0]    burst_rem, burst_rem_next;
  logic                          burst_acc, burst_acc_next;
  logic                          reading, reading_next;
  logic [RC_W-1:0]               rd_left, rd_left_next;

  // Result registers
  logic                          out_rd;
  logic                          emit;
  logic [brbf_pkg::STATUS_W-1:0] emit_status;
  logic                          emit_last;
  logic                          take;
  logic                          take_last;
  logic                          mem_we;

  // Working values
  logic [CAP_W-1:0]              free_now;
  logic [CAP_W-1:0]              free_next;
  logic [PW-1:0]                 wp_inc;
  logic [PW-1:0]                 rp_inc;
  logic [CAP_W-1:0]              rd_min;
  logic [RC_W-1:0]               rd_n;
  logic                          acc;
  logic [brbf_pkg::LEN_W-1:0]    rem;
  logic [brbf_pkg::LEN_W-1:0]    rem_dec;

  assign q_pop    = q_in.valid && !reading;
  assign idle     = !reading;
  assign free_now = cap_eff - used;
  assign wp_inc   = ((CAP_W'(wp) + CAP_W'(1)) == cap_eff) ? '0 : wp + PW'(1);
  assign rp_inc   = ((CAP_W'(rp) + CAP_W'(1)) == cap_eff) ? '0 : rp + PW'(1);
  assign rd_min   = (q_in.cmd.len < used) ? q_in.cmd.len : used;
  assign rd_n     = (32'(rd_min) > MAX_READ) ? RC_W'(MAX_READ) : RC_W'(rd_min);
  assign acc      = (burst_rem == '0) ? (free_now > q_in.cmd.len) : burst_acc;
  assign rem      = (burst_rem == '0) ? q_in.cmd.len : burst_rem;
  assign rem_dec  = rem - brbf_pkg::LEN_W'(1);

  // Decide the next state and the result of this cycle
  always_comb begin
    wp_next        = wp;
    rp_next        = rp;
    used_next      = used;
    burst_rem_next = burst_rem;
    burst_acc_next = burst_acc;
    reading_next   = reading;
    rd_left_next   = rd_left;
    emit           = 1'b0;
    emit_status    = brbf_pkg::STATUS_OK;
    emit_last      = 1'b1;
    take           = 1'b0;
    take_last      = 1'b0;
    mem_we         = 1'b0;

    if (reading) begin
      // Continue a read run
      take         = 1'b1;
      take_last    = (rd_left == RC_W'(1));
      rd_left_next = rd_left - RC_W'(1);
      reading_next = (rd_left != RC_W'(1));
    end else if (q_in.valid) begin
      unique case (q_in.cmd.req)
        brbf_pkg::REQ_WRITE: begin
          emit = 1'b1;
          if ((burst_rem == '0) && (q_in.cmd.len == '0)) begin
            emit_status = brbf_pkg::STATUS_ZERO_LEN;
          end else begin
            if (acc) begin
              mem_we      = 1'b1;
              wp_next     = wp_inc;
              used_next   = used + CAP_W'(1);
              emit_status = brbf_pkg::STATUS_OK;
            end else begin
              emit_status = brbf_pkg::STATUS_NO_SPACE;
            end
            burst_rem_next = rem_dec;
            burst_acc_next = (rem_dec != '0) ? acc : 1'b0;
          end
        end
        brbf_pkg::REQ_READ: begin
          if (q_in.cmd.len == '0) begin
            emit        = 1'b1;
            emit_status = brbf_pkg::STATUS_ZERO_LEN;
          end else if (used == '0) begin
            emit        = 1'b1;
            emit_status = brbf_pkg::STATUS_EMPTY;
          end else begin
            take         = 1'b1;
            take_last    = (rd_n == RC_W'(1));
            rd_left_next = rd_n - RC_W'(1);
            reading_next = (rd_n != RC_W'(1));
          end
        end
        brbf_pkg::REQ_CLEAR: begin
          emit           = 1'b1;
          wp_next        = '0;
          rp_next        = '0;
          used_next      = '0;
          burst_rem_next = '0;
          burst_acc_next = 1'b0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // Take one byte; an emptied store returns both pointers to zero
    if (take) begin
      emit        = 1'b1;
      emit_status = brbf_pkg::STATUS_OK;
      emit_last   = take_last;
      used_next   = used - CAP_W'(1);
      if (used == CAP_W'(1)) begin
        rp_next = '0;
        wp_next = '0;
      end else begin
        rp_next = rp_inc;
      end
    end
  end

  assign free_next = cap_eff - used_next;

  // Write and read the store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= q_in.cmd.data;
    end
    if (take) begin
      mem_q <= mem[rp];
    end
  end

  // Update control state; a capacity write empties the FIFO
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff   <= cap_clamp(brbf_pkg::CAP_RESET);
      wp        <= '0;
      rp        <= '0;
      used      <= '0;
      burst_rem <= '0;
      burst_acc <= 1'b0;
      reading   <= 1'b0;
      rd_left   <= '0;
      done      <= 1'b0;
    end else if (cfg_we) begin
      cap_eff   <= cap_clamp(cfg_data);
      wp        <= '0;
      rp        <= '0;
      used      <= '0;
      burst_rem <= '0;
      burst_acc <= 1'b0;
      reading   <= 1'b0;
      rd_left   <= '0;
      done      <= 1'b0;
    end else begin
      wp        <= wp_next;
      rp        <= rp_next;
      used      <= used_next;
      burst_rem <= burst_rem_next;
      burst_acc <= burst_acc_next;
      reading   <= reading_next;
      rd_left   <= rd_left_next;
      done      <= emit;
    end
  end

  // Hold the result fields for the strobe cycle
  always_ff @(posedge clk) begin
    if (emit) begin
      status     <= emit_status;
      last       <= emit_last;
      out_rd     <= take;
      used_count <= brbf_pkg::USED_W'(used_next);
      free_count <= free_next;
    end
  end

  assign read_byte = out_rd ? mem_q : '0;

endmodule

// ----- rtl/core/byte_ring_buffer_fifo_core.sv -----
// A command waits in the front queue until the back end pops it; its first result is then registered on done.
// Throughput: one write, clear or short read per cycle while no read run holds the
// back end; a read run gives one byte per cycle from the store's single read port.
// A two-entry queue lets commands be taken while a read run is in progress.
// Reset clears pointers, fill count, burst state and sets capacity to 1024 (clamped
// to the store depth); store contents are not cleared. Results cannot be stalled.
`include "assert_macros.svh"

module byte_ring_buffer_fifo_core #(
  parameter int STORE_DEPTH = 1024,
  parameter int MAX_READ    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [brbf_pkg::REQ_W-1:0]     req_type,
  input  logic [brbf_pkg::DATA_W-1:0]    data_byte,
  input  logic [brbf_pkg::LEN_W-1:0]     burst_length,
  output logic                           done,
  output logic [brbf_pkg::STATUS_W-1:0]  status,
  output logic [brbf_pkg::DATA_W-1:0]    read_byte,
  output logic                           last,
  output logic [brbf_pkg::USED_W-1:0]    used_count,
  output logic [brbf_pkg::CAP_W-1:0]     free_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [brbf_pkg::CAP_W-1:0]     cfg_data
);

  brbf_pkg::cmd_chan_t q_chan;
  logic                q_pop;
  logic                back_idle;
  logic                cfg_we;

  // Take capacity writes only when nothing is queued or running
  assign cfg_ready = back_idle && !q_chan.valid;
  assign cfg_we    = cfg_valid && cfg_ready;

  brbf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .burst_length (burst_length),
    .q_out        (q_chan),
    .q_pop        (q_pop)
  );

  brbf_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_in       (q_chan),
    .q_pop      (q_pop),
    .idle       (back_idle),
    .done       (done),
    .status     (status),
    .read_byte  (read_byte),
    .last       (last),
    .used_count (used_count),
    .free_count (free_count)
  );

  // The store never fills completely
  `ASSERT_IMP(a_free_nonzero, clk, rst, done, free_count != '0)
  // Nothing-to-read results report an empty store
  `ASSERT_IMP(a_empty_used, clk, rst, done && (status == brbf_pkg::STATUS_EMPTY), used_count == '0)
  // A full queue has a command waiting for the back end
  `ASSERT_IMP(a_busy_queued, clk, rst, busy, q_chan.valid)
  // Every popped command gives a result next cycle
  `ASSERT_NXT(a_pop_result, clk, rst, q_pop && !cfg_we, done)

endmodule

// ----- tb/byte_ring_buffer_fifo_core_tb.sv -----
// Self-checking testbench for the circular byte FIFO core with burst-checked writes
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_core_tb;

  localparam int REQ_W       = brbf_pkg::REQ_W;
  localparam int DATA_W      = brbf_pkg::DATA_W;
  localparam int LEN_W       = brbf_pkg::LEN_W;
  localparam int CAP_W       = brbf_pkg::CAP_W;
  localparam int USED_W      = brbf_pkg::USED_W;
  localparam int STATUS_W    = brbf_pkg::STATUS_W;

  localparam int RING_DEPTH  = 1024;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int READ_CAP    = 64;
  localparam int DIR_ROWS    = 23;
  localparam int ROW_IW      = $clog2(DIR_ROWS);
  localparam int PHASES      = 10;
  localparam int PHASE_IW    = $clog2(PHASES);
  localparam int PHASE_ITEMS = 16;

  // One result as it leaves the block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   rbyte;
    logic                last;
    logic [USED_W-1:0]   used;
    logic [CAP_W-1:0]    free;
  } fifo_reply_t;

  // One directed command; the reply is typed in only where typed is set
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              typed;
    fifo_reply_t       reply;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   req_type;
  logic [DATA_W-1:0]  data_byte;
  logic [LEN_W-1:0]   burst_length;
  logic               done;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]  read_byte;
  logic               last;
  logic [USED_W-1:0]  used_count;
  logic [CAP_W-1:0]   free_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data;

  // Mirror of the FIFO state
  logic [DATA_W-1:0]  ring_store [0:RING_DEPTH-1];
  logic [CAP_W-1:0]   cap_reg;
  int                 wr_ptr;
  int                 rd_ptr;
  int                 burst_left;
  bit                 burst_ok;

  fifo_reply_t        reply_queue [$];
  fifo_reply_t        want;
  int                 fail_count;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{brbf_pkg::REQ_READ,  8'h00, 11'd5,    1'b1,
      '{brbf_pkg::STATUS_EMPTY,    8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_READ,  8'h00, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_ZERO_LEN, 8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'h00, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_ZERO_LEN, 8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_NONE,  8'h00, 11'd0,    1'b0, '0},
    '{brbf_pkg::REQ_WRITE, 8'hFF, 11'd3,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_WRITE, 8'h00, 11'd2047, 1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd2, 11'd1022}},
    '{brbf_pkg::REQ_WRITE, 8'hA5, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd3, 11'd1021}},
    '{brbf_pkg::REQ_READ,  8'h00, 11'd2047, 1'b0, '0},
    '{brbf_pkg::REQ_WRITE, 8'h5A, 11'd1024, 1'b1,
      '{brbf_pkg::STATUS_NO_SPACE, 8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'h11, 11'd1,    1'b1,
      '{brbf_pkg::STATUS_NO_SPACE, 8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_CLEAR, 8'h00, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'h80, 11'd1023, 1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_WRITE, 8'h01, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd2, 11'd1022}},
    '{brbf_pkg::REQ_CLEAR, 8'h00, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'h12, 11'd2,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_READ,  8'h00, 11'd1,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h12, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'h34, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_READ,  8'h00, 11'd64,   1'b1,
      '{brbf_pkg::STATUS_OK,       8'h34, 1'b1, 10'd0, 11'd1024}},
    '{brbf_pkg::REQ_WRITE, 8'hAA, 11'd1,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_WRITE, 8'h55, 11'd1,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd2, 11'd1022}},
    '{brbf_pkg::REQ_NONE,  8'hFF, 11'd2047, 1'b0, '0},
    '{brbf_pkg::REQ_READ,  8'h00, 11'd1,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'hAA, 1'b1, 10'd1, 11'd1023}},
    '{brbf_pkg::REQ_CLEAR, 8'h00, 11'd0,    1'b1,
      '{brbf_pkg::STATUS_OK,       8'h00, 1'b1, 10'd0, 11'd1024}}
  };

  byte_ring_buffer_fifo_core #(
    .STORE_DEPTH (RING_DEPTH),
    .MAX_READ    (READ_CAP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .burst_length (burst_length),
    .done         (done),
    .status       (status),
    .read_byte    (read_byte),
    .last         (last),
    .used_count   (used_count),
    .free_count   (free_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp the capacity register to the usable store range
  function automatic int clamp_cap(input logic [CAP_W-1:0] value);
    if (value < brbf_pkg::CAP_MIN) return int'(brbf_pkg::CAP_MIN);
    if (value > RING_DEPTH) return RING_DEPTH;
    return int'(value);
  endfunction

  function automatic int ring_used();
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return clamp_cap(cap_reg) - (rd_ptr - wr_ptr);
  endfunction

  function automatic void ring_empty();
    wr_ptr     = 0;
    rd_ptr     = 0;
    burst_left = 0;
    burst_ok   = 1'b0;
  endfunction

  // Queue one reply carrying the fill level after the step
  function automatic void reply_push(input logic [STATUS_W-1:0] st,
                                     input logic [DATA_W-1:0] b, input logic l);
    fifo_reply_t r;
    int          used;
    used    = ring_used();
    r.status = st;
    r.rbyte  = b;
    r.last   = l;
    r.used   = USED_W'(used);
    r.free   = CAP_W'(clamp_cap(cap_reg) - used);
    reply_queue.push_back(r);
  endfunction

  // Advance the mirror by one accepted command and queue its replies
  function automatic void ring_apply(input logic [REQ_W-1:0] req,
                                     input logic [DATA_W-1:0] data,
                                     input logic [LEN_W-1:0] len);
    int                  ecap;
    int                  count;
    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   b;
    ecap = clamp_cap(cap_reg);
    case (req)
      brbf_pkg::REQ_WRITE: begin
        if (burst_left == 0 && len == 0) begin
          reply_push(brbf_pkg::STATUS_ZERO_LEN, '0, 1'b1);
        end else begin
          // The first byte of a burst decides the fate of the whole burst
          if (burst_left == 0) begin
            burst_ok   = (ecap - ring_used()) > int'(len);
            burst_left = int'(len);
          end
          if (burst_ok) begin
            ring_store[PTR_W'(wr_ptr)] = data;
            wr_ptr = (wr_ptr + 1) % ecap;
            st = brbf_pkg::STATUS_OK;
          end else begin
            st = brbf_pkg::STATUS_NO_SPACE;
          end
          burst_left--;
          if (burst_left == 0) burst_ok = 1'b0;
          reply_push(st, '0, 1'b1);
        end
      end
      brbf_pkg::REQ_READ: begin
        count = ring_used();
        if (len == 0) begin
          reply_push(brbf_pkg::STATUS_ZERO_LEN, '0, 1'b1);
        end else if (count == 0) begin
          reply_push(brbf_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          if (int'(len) < count) count = int'(len);
          if (count > READ_CAP) count = READ_CAP;
          for (int i = 0; i < count; i++) begin
            b = ring_store[PTR_W'(rd_ptr)];
            rd_ptr = (rd_ptr + 1) % ecap;
            // Draining to empty pulls both pointers home
            if (rd_ptr == wr_ptr) begin
              rd_ptr = 0;
              wr_ptr = 0;
            end
            reply_push(brbf_pkg::STATUS_OK, b, i + 1 == count);
          end
        end
      end
      brbf_pkg::REQ_CLEAR: begin
        ring_empty();
        reply_push(brbf_pkg::STATUS_OK, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Present one command after a random gap unless quiet, and hold it until the transfer
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                           input logic [LEN_W-1:0] len, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req_type     <= req;
    data_byte    <= data;
    burst_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring_apply(req, data, len);
  endtask

  task automatic wait_drained();
    while (reply_queue.size() != 0) @(posedge clk);
  endtask

  // Write the capacity only once the block has gone idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    start <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = value;
    ring_empty();
  endtask

  // Random traffic: mostly whole bursts with random content, mixed with reads,
  // clears, zero lengths, ignored codes and oversize bursts cut short by a clear
  task automatic run_phase(input int target, input bit quiet);
    int               sent;
    int               bytes_left;
    int               pick;
    int               ecap;
    int               blen;
    bit               clear_due;
    logic [LEN_W-1:0] rlen;
    sent       = 0;
    bytes_left = 0;
    clear_due  = 1'b0;
    ecap       = clamp_cap(cap_reg);
    while (sent < target || bytes_left > 0 || clear_due) begin
      pick = $urandom_range(0, 99);
      if (bytes_left > 0 && pick < 88) begin
        send_item(brbf_pkg::REQ_WRITE, DATA_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 2047)), quiet);
        bytes_left--;
        sent++;
      end else if (bytes_left == 0 && clear_due) begin
        send_item(brbf_pkg::REQ_CLEAR, DATA_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 2047)), quiet);
        clear_due = 1'b0;
        sent++;
      end else if (bytes_left > 0 || pick < 35) begin
        case ($urandom_range(0, 9))
          0:       rlen = '0;
          1:       rlen = LEN_W'($urandom_range(0, 2047));
          2, 3:    rlen = LEN_W'($urandom_range(1, 80));
          default: rlen = LEN_W'($urandom_range(1, 8));
        endcase
        send_item(brbf_pkg::REQ_READ, DATA_W'($urandom_range(0, 255)), rlen, quiet);
        sent++;
      end else if (pick < 72) begin
        case ($urandom_range(0, 9))
          9: begin
            blen       = $urandom_range(1, 2047);
            bytes_left = (blen - 1 > 5) ? 5 : blen - 1;
            clear_due  = (blen - 1 > 5);
          end
          7, 8: begin
            blen       = $urandom_range(1, (ecap + 2 < 90) ? ecap + 2 : 90);
            bytes_left = blen - 1;
          end
          default: begin
            blen       = $urandom_range(1, (ecap < 24) ? ecap : 24);
            bytes_left = blen - 1;
          end
        endcase
        send_item(brbf_pkg::REQ_WRITE, DATA_W'($urandom_range(0, 255)), LEN_W'(blen),
                  quiet);
        sent++;
      end else if (pick < 82) begin
        send_item(brbf_pkg::REQ_CLEAR, DATA_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 2047)), quiet);
        sent++;
      end else if (pick < 92) begin
        send_item(brbf_pkg::REQ_WRITE, DATA_W'($urandom_range(0, 255)), '0, quiet);
        sent++;
      end else begin
        // Unused code: no reply, not counted
        send_item(brbf_pkg::REQ_NONE, DATA_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 2047)), quiet);
      end
    end
  endtask

  // Compare every reply with the oldest one still owed
  always @(posedge clk) begin
    if (!rst && done) begin
      if (reply_queue.size() == 0) begin
        $error("unexpected result transfer: status %0d read_byte %0h", status, read_byte);
        fail_count++;
      end else begin
        want = reply_queue.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (read_byte !== want.rbyte) begin
          $error("read_byte: expected %0h, got %0h", want.rbyte, read_byte);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
        if (used_count !== want.used) begin
          $error("used_count: expected %0d, got %0d", want.used, used_count);
          fail_count++;
        end
        if (free_count !== want.free) begin
          $error("free_count: expected %0d, got %0d", want.free, free_count);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [CAP_W-1:0] caps [PHASES];
    caps = '{11'd2, 11'd0, 11'd3, 11'd1, 11'd17, 11'd2047, 11'd1024, 11'd64, 11'd1025,
             11'd2};
    caps[PHASES-1] = CAP_W'($urandom_range(2, RING_DEPTH));
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = brbf_pkg::REQ_NONE;
    data_byte    = '0;
    burst_length = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    fail_count   = 0;
    cap_reg      = brbf_pkg::CAP_RESET;
    ring_empty();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset capacity
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[ROW_IW'(i)].req, dir_rows[ROW_IW'(i)].data,
                dir_rows[ROW_IW'(i)].len, 1'b0);
      if (dir_rows[ROW_IW'(i)].typed) begin
        reply_queue[reply_queue.size() - 1] = dir_rows[ROW_IW'(i)].reply;
      end
    end

    // Random phases, one capacity each
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[PHASE_IW'(p)]);
      run_phase(PHASE_ITEMS, $urandom_range(0, 3) == 0);
    end

    start <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS byte_ring_buffer_fifo_core");
    end else begin
      $display("FAIL byte_ring_buffer_fifo_core");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("FAIL byte_ring_buffer_fifo_core");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/brbf_pkg.sv
rtl/core/brbf_front.sv
rtl/core/brbf_back.sv
rtl/core/byte_ring_buffer_fifo_core.sv
tb/byte_ring_buffer_fifo_core_tb.sv
